// ----- hw/rtl/ring_buffer_positional_list_top_assert.svh -----
// assertion macros for the ring buffer positional list
`ifndef RING_BUFFER_POSITIONAL_LIST_TOP_ASSERT_SVH
`define RING_BUFFER_POSITIONAL_LIST_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RBPL_CHK_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbpl check failed");

// next-cycle implication, checked outside reset
`define RBPL_CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbpl check failed");

`endif

// ----- hw/rtl/rbpl_pkg.sv -----
// shared types and codes for the ring buffer positional list
package rbpl_pkg;

  typedef enum logic [2:0] {
    K_SET        = 3'd0,
    K_INSERT     = 3'd1,
    K_PREPEND    = 3'd2,
    K_REMOVE     = 3'd3,
    K_GET        = 3'd4,
    K_FIND       = 3'd5,
    K_REMOVE_ONE = 3'd6,
    K_REMOVE_ALL = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WM_COPY_UP,
    WM_COPY_DOWN,
    WM_FIND,
    WM_COMPACT
  } walk_mode_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_FAIL,
    CMD_READ_SLOT,
    CMD_CAPTURE,
    CMD_WRITE_SLOT,
    CMD_INS_SETUP,
    CMD_DEL_SETUP,
    CMD_SCAN_SETUP,
    CMD_WALK,
    CMD_HEAD_INC,
    CMD_COUNT_DEC,
    CMD_INS_DONE,
    CMD_PREPEND,
    CMD_COMPACT_DONE,
    CMD_NOT_FOUND,
    CMD_EMIT
  } dp_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CAPT,
    S_SETW,
    S_REMOVE,
    S_DEL_WALK,
    S_INS_WALK,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    kind_t   kind;
    status_t check;
    logic    pos_zero;
    logic    walk_done;
    logic    found;
    logic    out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [6:0]         position;
    logic [31:0]        value;
    logic signed [15:0] entry_type;
  } in_t;

  typedef struct packed {
    logic [31:0]        result_value;
    logic signed [15:0] result_type;
    logic [6:0]         result_index;
    logic [6:0]         entries_now;
    logic [1:0]         status;
  } out_t;

endpackage

// ----- hw/rtl/rbpl_ram.sv -----
// generic simple dual-port ram with registered read
module rbpl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rbpl_ctrl.sv -----
// sequencer for the ring buffer positional list
module rbpl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbpl_pkg::dp_stat_t stat,
  output rbpl_pkg::dp_cmd_t  cmd
);

  rbpl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbpl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == rbpl_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = rbpl_pkg::CMD_NONE;
    case (state_r)
      rbpl_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd       = rbpl_pkg::CMD_LATCH;
          state_nxt = rbpl_pkg::S_CHECK;
        end
      end
      rbpl_pkg::S_CHECK: begin
        if (stat.check != rbpl_pkg::ST_OK) begin
          cmd       = rbpl_pkg::CMD_FAIL;
          state_nxt = rbpl_pkg::S_FINISH;
        end else begin
          case (stat.kind)
            rbpl_pkg::K_SET, rbpl_pkg::K_GET, rbpl_pkg::K_REMOVE: begin
              cmd       = rbpl_pkg::CMD_READ_SLOT;
              state_nxt = rbpl_pkg::S_CAPT;
            end
            rbpl_pkg::K_INSERT: begin
              cmd       = rbpl_pkg::CMD_INS_SETUP;
              state_nxt = rbpl_pkg::S_INS_WALK;
            end
            rbpl_pkg::K_PREPEND: begin
              cmd       = rbpl_pkg::CMD_PREPEND;
              state_nxt = rbpl_pkg::S_FINISH;
            end
            default: begin
              cmd       = rbpl_pkg::CMD_SCAN_SETUP;
              state_nxt = rbpl_pkg::S_SCAN;
            end
          endcase
        end
      end
      rbpl_pkg::S_CAPT: begin
        cmd = rbpl_pkg::CMD_CAPTURE;
        case (stat.kind)
          rbpl_pkg::K_SET:    state_nxt = rbpl_pkg::S_SETW;
          rbpl_pkg::K_REMOVE: state_nxt = rbpl_pkg::S_REMOVE;
          default:            state_nxt = rbpl_pkg::S_FINISH;
        endcase
      end
      rbpl_pkg::S_SETW: begin
        cmd       = rbpl_pkg::CMD_WRITE_SLOT;
        state_nxt = rbpl_pkg::S_FINISH;
      end
      rbpl_pkg::S_REMOVE: begin
        // removing the first entry only moves the head and lowers the count
        if (stat.pos_zero) begin
          cmd       = rbpl_pkg::CMD_HEAD_INC;
          state_nxt = rbpl_pkg::S_FINISH;
        end else begin
          cmd       = rbpl_pkg::CMD_DEL_SETUP;
          state_nxt = rbpl_pkg::S_DEL_WALK;
        end
      end
      rbpl_pkg::S_DEL_WALK: begin
        if (stat.walk_done) begin
          cmd       = rbpl_pkg::CMD_COUNT_DEC;
          state_nxt = rbpl_pkg::S_FINISH;
        end else begin
          cmd = rbpl_pkg::CMD_WALK;
        end
      end
      rbpl_pkg::S_INS_WALK: begin
        if (stat.walk_done) begin
          cmd       = rbpl_pkg::CMD_INS_DONE;
          state_nxt = rbpl_pkg::S_FINISH;
        end else begin
          cmd = rbpl_pkg::CMD_WALK;
        end
      end
      rbpl_pkg::S_SCAN: begin
        if (!stat.walk_done) begin
          cmd = rbpl_pkg::CMD_WALK;
        end else if (stat.kind == rbpl_pkg::K_REMOVE_ALL) begin
          cmd       = rbpl_pkg::CMD_COMPACT_DONE;
          state_nxt = rbpl_pkg::S_FINISH;
        end else if (!stat.found) begin
          cmd       = rbpl_pkg::CMD_NOT_FOUND;
          state_nxt = rbpl_pkg::S_FINISH;
        end else if (stat.kind == rbpl_pkg::K_REMOVE_ONE) begin
          state_nxt = rbpl_pkg::S_REMOVE;
        end else begin
          state_nxt = rbpl_pkg::S_FINISH;
        end
      end
      rbpl_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd       = rbpl_pkg::CMD_EMIT;
          state_nxt = rbpl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rbpl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/rbpl_datapath.sv -----
// list storage, pointers, walk engine and result register
module rbpl_datapath #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               keep_tags,
  input  rbpl_pkg::in_t      in_data,
  input  rbpl_pkg::dp_cmd_t  cmd,
  output rbpl_pkg::dp_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output rbpl_pkg::out_t     out_data
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > 7) ? CW : 7;
  localparam int RW  = DATA_WIDTH + 16;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] a);
    return (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] step_dn(input logic [AW-1:0] a);
    return (a == '0) ? AW'(CAPACITY - 1) : a - 1'b1;
  endfunction

  // one subtract wraps the sum while the offset is at most capacity; larger ones fail the check
  function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] h, input logic [PW-1:0] x);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(x);
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  // control state
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic                  rv_r, rv_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rbpl_pkg::kind_t       kind_r, kind_nxt;
  rbpl_pkg::walk_mode_t  mode_r, mode_nxt;
  rbpl_pkg::status_t     res_status_r, res_status_nxt;

  // payload
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [15:0]           tag_r, tag_nxt;
  logic [AW-1:0]         src_r, src_nxt;
  logic [AW-1:0]         dst_r, dst_nxt;
  logic [AW-1:0]         rda_r, rda_nxt;
  logic [CW-1:0]         w_r, w_nxt;
  logic [PW-1:0]         idx_r, idx_nxt;
  logic [31:0]           res_value_r, res_value_nxt;
  logic [15:0]           res_type_r, res_type_nxt;
  logic [6:0]            res_index_r, res_index_nxt;
  rbpl_pkg::out_t        out_data_r, out_data_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [15:0]           rd_tag;
  logic [AW-1:0]         end_slot;
  logic                  hit;
  logic                  stop;
  logic                  full;
  logic [PW-1:0]         count_p;
  rbpl_pkg::status_t     check;

  rbpl_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val   = ram_rdata[DATA_WIDTH-1:0];
  assign rd_tag   = ram_rdata[RW-1 -: 16];
  assign count_p  = PW'(count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign end_slot = mod_add(head_r, count_p);

  always_comb begin
    check = rbpl_pkg::ST_OK;
    case (kind_r)
      rbpl_pkg::K_SET, rbpl_pkg::K_GET, rbpl_pkg::K_REMOVE: begin
        if (pos_r >= count_p) check = rbpl_pkg::ST_RANGE;
      end
      rbpl_pkg::K_INSERT: begin
        if (pos_r > count_p) check = rbpl_pkg::ST_RANGE;
        else if (full)       check = rbpl_pkg::ST_FULL;
      end
      rbpl_pkg::K_PREPEND: begin
        if (full) check = rbpl_pkg::ST_FULL;
      end
      default: check = rbpl_pkg::ST_OK;
    endcase
  end

  assign stat.kind      = kind_r;
  assign stat.check     = check;
  assign stat.pos_zero  = (pos_r == '0);
  assign stat.walk_done = (left_r == '0) && !rv_r;
  assign stat.found     = found_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    rv_nxt         = 1'b0;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    mode_nxt       = mode_r;
    res_status_nxt = res_status_r;
    pos_nxt        = pos_r;
    slot_nxt       = slot_r;
    val_nxt        = val_r;
    tag_nxt        = tag_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    rda_nxt        = rda_r;
    w_nxt          = w_r;
    idx_nxt        = idx_r;
    res_value_nxt  = res_value_r;
    res_type_nxt   = res_type_r;
    res_index_nxt  = res_index_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = {tag_r, val_r};
    ram_raddr      = src_r;
    hit            = 1'b0;
    stop           = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (cmd)
      rbpl_pkg::CMD_LATCH: begin
        kind_nxt       = rbpl_pkg::kind_t'(in_data.kind);
        pos_nxt        = PW'(in_data.position);
        slot_nxt       = mod_add(head_r, PW'(in_data.position));
        val_nxt        = DATA_WIDTH'(in_data.value);
        tag_nxt        = keep_tags ? in_data.entry_type : 16'd0;
        res_value_nxt  = '0;
        res_type_nxt   = '0;
        res_index_nxt  = '0;
        res_status_nxt = rbpl_pkg::ST_OK;
        found_nxt      = 1'b0;
      end
      rbpl_pkg::CMD_FAIL: begin
        res_status_nxt = check;
      end
      rbpl_pkg::CMD_READ_SLOT: begin
        ram_raddr = slot_r;
      end
      rbpl_pkg::CMD_CAPTURE: begin
        res_value_nxt = 32'(rd_val);
        res_type_nxt  = keep_tags ? rd_tag : 16'd0;
        res_index_nxt = 7'(pos_r);
      end
      rbpl_pkg::CMD_WRITE_SLOT: begin
        ram_we = 1'b1;
      end
      rbpl_pkg::CMD_INS_SETUP: begin
        // copy from the tail backward, one slot toward the end
        dst_nxt  = end_slot;
        src_nxt  = step_dn(end_slot);
        left_nxt = count_r - CW'(pos_r);
        mode_nxt = rbpl_pkg::WM_COPY_DOWN;
      end
      rbpl_pkg::CMD_DEL_SETUP: begin
        dst_nxt  = slot_r;
        src_nxt  = step_up(slot_r);
        left_nxt = count_r - CW'(pos_r) - CW'(1);
        mode_nxt = rbpl_pkg::WM_COPY_UP;
      end
      rbpl_pkg::CMD_SCAN_SETUP: begin
        src_nxt  = head_r;
        dst_nxt  = head_r;
        left_nxt = count_r;
        w_nxt    = '0;
        idx_nxt  = '0;
        mode_nxt = (kind_r == rbpl_pkg::K_REMOVE_ALL) ? rbpl_pkg::WM_COMPACT
                                                      : rbpl_pkg::WM_FIND;
      end
      rbpl_pkg::CMD_WALK: begin
        // read data of the previous cycle is handled while the next read goes out
        if (rv_r) begin
          hit = (rd_val == val_r);
          case (mode_r)
            rbpl_pkg::WM_COPY_UP: begin
              ram_we    = 1'b1;
              ram_waddr = dst_r;
              ram_wdata = ram_rdata;
              dst_nxt   = step_up(dst_r);
            end
            rbpl_pkg::WM_COPY_DOWN: begin
              ram_we    = 1'b1;
              ram_waddr = dst_r;
              ram_wdata = ram_rdata;
              dst_nxt   = step_dn(dst_r);
            end
            rbpl_pkg::WM_FIND: begin
              if (hit) begin
                stop          = 1'b1;
                found_nxt     = 1'b1;
                pos_nxt       = idx_r;
                slot_nxt      = rda_r;
                res_value_nxt = 32'(rd_val);
                res_type_nxt  = keep_tags ? rd_tag : 16'd0;
                res_index_nxt = 7'(idx_r);
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            default: begin
              if (!hit) begin
                ram_we    = 1'b1;
                ram_waddr = dst_r;
                ram_wdata = ram_rdata;
                dst_nxt   = step_up(dst_r);
                w_nxt     = w_r + 1'b1;
              end
            end
          endcase
        end
        if (stop) begin
          left_nxt = '0;
        end else if (left_r != '0) begin
          rv_nxt   = 1'b1;
          rda_nxt  = src_r;
          left_nxt = left_r - 1'b1;
          src_nxt  = (mode_r == rbpl_pkg::WM_COPY_DOWN) ? step_dn(src_r) : step_up(src_r);
        end
      end
      rbpl_pkg::CMD_HEAD_INC: begin
        head_nxt  = step_up(head_r);
        count_nxt = count_r - 1'b1;
      end
      rbpl_pkg::CMD_COUNT_DEC: begin
        count_nxt = count_r - 1'b1;
      end
      rbpl_pkg::CMD_INS_DONE: begin
        ram_we        = 1'b1;
        count_nxt     = count_r + 1'b1;
        res_index_nxt = 7'(pos_r);
      end
      rbpl_pkg::CMD_PREPEND: begin
        head_nxt  = step_dn(head_r);
        ram_we    = 1'b1;
        ram_waddr = step_dn(head_r);
        count_nxt = count_r + 1'b1;
      end
      rbpl_pkg::CMD_COMPACT_DONE: begin
        count_nxt      = w_r;
        res_index_nxt  = 7'(count_r - w_r);
        res_status_nxt = (count_r == w_r) ? rbpl_pkg::ST_MISSING : rbpl_pkg::ST_OK;
      end
      rbpl_pkg::CMD_NOT_FOUND: begin
        res_status_nxt = rbpl_pkg::ST_MISSING;
      end
      rbpl_pkg::CMD_EMIT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.result_value = res_value_r;
        out_data_nxt.result_type  = res_type_r;
        out_data_nxt.result_index = res_index_r;
        out_data_nxt.entries_now  = 7'(count_r);
        out_data_nxt.status       = res_status_r;
      end
      default: begin
        rv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      count_r      <= '0;
      left_r       <= '0;
      rv_r         <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      kind_r       <= rbpl_pkg::K_SET;
      mode_r       <= rbpl_pkg::WM_COPY_UP;
      res_status_r <= rbpl_pkg::ST_OK;
    end else begin
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      left_r       <= left_nxt;
      rv_r         <= rv_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      kind_r       <= kind_nxt;
      mode_r       <= mode_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    slot_r      <= slot_nxt;
    val_r       <= val_nxt;
    tag_r       <= tag_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    rda_r       <= rda_nxt;
    w_r         <= w_nxt;
    idx_r       <= idx_nxt;
    res_value_r <= res_value_nxt;
    res_type_r  <= res_type_nxt;
    res_index_r <= res_index_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/ring_buffer_positional_list_top.sv -----
// top level of the ring buffer positional list
//
//   port group   direction   handshake            payload
//   in_*         input       in_valid / in_ready  rbpl_pkg::in_t
//   out_*        output      out_valid/out_ready  rbpl_pkg::out_t
//   p*           config      psel/penable/pready  keep_type_tags at 0x0
//
// one transaction at a time; the list lives in a single ram, one entry per cycle.
// errors and prepend skip the ram read; get, set and remove read the addressed slot;
// insert and the removes not at the head walk the entries they move; find stops at its
// first hit, while a miss and remove all walk every entry; remove first then removes its
// hit like remove; a result still waiting in the output register holds the next
// transaction in its last state; reset empties the list.
module ring_buffer_positional_list_top #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rbpl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rbpl_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic               keep_r, keep_nxt;
  logic               cfg_wr;
  rbpl_pkg::dp_cmd_t  cmd;
  rbpl_pkg::dp_stat_t stat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign keep_nxt = (cfg_wr && !paddr[2]) ? pwdata[0] : keep_r;
  assign prdata   = paddr[2] ? 32'd0 : {31'd0, keep_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 1'b0;
    end else begin
      keep_r <= keep_nxt;
    end
  end

  rbpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbpl_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .keep_tags (keep_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`include "ring_buffer_positional_list_top_assert.svh"

  `RBPL_CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `RBPL_CHK_IMPL(a_fail_is_clean, out_valid && out_data.status != rbpl_pkg::ST_OK,
                 out_data.result_value == '0 && out_data.result_type == '0)
  `RBPL_CHK_IMPL(a_walk_only_when_busy, cmd == rbpl_pkg::CMD_WALK, !in_ready)
  `RBPL_CHK_IMPL(a_emit_only_when_free, cmd == rbpl_pkg::CMD_EMIT, stat.out_free)

endmodule

// ----- verif/rbpl_checker.sv -----
// checker for the ring buffer positional list: predicts each result and compares it
module rbpl_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  rbpl_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  rbpl_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic  [2:0]    paddr,
  input  logic  [31:0]   pwdata,
  input  logic           pready,
  output int             fail_count,
  output int             pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;

  logic [31:0]    list_data [CAP];
  logic [15:0]    list_tag [CAP];
  logic [5:0]     head_q;
  int             count_q;
  logic           keep_tags;
  rbpl_pkg::out_t expected_q[$];

  function automatic logic [5:0] slot_of(int p);
    return 6'((int'(head_q) + p) % CAP);
  endfunction

  function automatic rbpl_pkg::out_t result_of(logic [31:0] v, logic [15:0] t, int idx,
                                               rbpl_pkg::status_t st);
    rbpl_pkg::out_t r;
    r.result_value = v;
    r.result_type = t;
    r.result_index = 7'(idx);
    r.entries_now = 7'(count_q);
    r.status = st;
    return r;
  endfunction

  // shift the entries behind pos toward the head, or advance head at pos 0
  task automatic drop_at(int pos);
    if (pos == 0) begin
      head_q = head_q + 6'd1;
    end else begin
      for (int i = pos; i + 1 < count_q; i++) begin
        list_data[slot_of(i)] = list_data[slot_of(i + 1)];
        list_tag[slot_of(i)] = list_tag[slot_of(i + 1)];
      end
    end
    count_q--;
  endtask

  task automatic apply_op(rbpl_pkg::in_t it);
    int             pos;
    logic [15:0]    tg;
    logic [31:0]    ov;
    logic [15:0]    ot;
    logic [5:0]     s;
    int             w;
    int             removed;
    int             p;
    rbpl_pkg::out_t r;
    pos = int'(it.position);
    tg = keep_tags ? it.entry_type : 16'd0;
    p = -1;
    case (rbpl_pkg::kind_t'(it.kind))
      rbpl_pkg::K_SET, rbpl_pkg::K_GET, rbpl_pkg::K_REMOVE: begin
        if (pos >= count_q) begin
          r = result_of(0, 0, 0, rbpl_pkg::ST_RANGE);
        end else begin
          s = slot_of(pos);
          ov = list_data[s];
          ot = keep_tags ? list_tag[s] : 16'd0;
          if (it.kind == rbpl_pkg::K_SET) begin
            list_data[s] = it.value;
            list_tag[s] = tg;
          end else if (it.kind == rbpl_pkg::K_REMOVE) begin
            drop_at(pos);
          end
          r = result_of(ov, ot, pos, rbpl_pkg::ST_OK);
        end
      end
      rbpl_pkg::K_INSERT: begin
        if (pos > count_q) r = result_of(0, 0, 0, rbpl_pkg::ST_RANGE);
        else if (count_q >= CAP) r = result_of(0, 0, 0, rbpl_pkg::ST_FULL);
        else begin
          for (int i = count_q; i > pos; i--) begin
            list_data[slot_of(i)] = list_data[slot_of(i - 1)];
            list_tag[slot_of(i)] = list_tag[slot_of(i - 1)];
          end
          list_data[slot_of(pos)] = it.value;
          list_tag[slot_of(pos)] = tg;
          count_q++;
          r = result_of(0, 0, pos, rbpl_pkg::ST_OK);
        end
      end
      rbpl_pkg::K_PREPEND: begin
        if (count_q >= CAP) r = result_of(0, 0, 0, rbpl_pkg::ST_FULL);
        else begin
          head_q = head_q - 6'd1;
          list_data[head_q] = it.value;
          list_tag[head_q] = tg;
          count_q++;
          r = result_of(0, 0, 0, rbpl_pkg::ST_OK);
        end
      end
      rbpl_pkg::K_FIND, rbpl_pkg::K_REMOVE_ONE: begin
        for (int i = 0; i < count_q; i++)
          if (p < 0 && list_data[slot_of(i)] == it.value) p = i;
        if (p < 0) r = result_of(0, 0, 0, rbpl_pkg::ST_MISSING);
        else begin
          s = slot_of(p);
          ov = list_data[s];
          ot = keep_tags ? list_tag[s] : 16'd0;
          if (it.kind == rbpl_pkg::K_REMOVE_ONE) drop_at(p);
          r = result_of(ov, ot, p, rbpl_pkg::ST_OK);
        end
      end
      default: begin
        w = 0;
        removed = 0;
        for (int i = 0; i < count_q; i++) begin
          if (list_data[slot_of(i)] == it.value) removed++;
          else begin
            list_data[slot_of(w)] = list_data[slot_of(i)];
            list_tag[slot_of(w)] = list_tag[slot_of(i)];
            w++;
          end
        end
        count_q = w;
        r = result_of(0, 0, removed, removed != 0 ? rbpl_pkg::ST_OK : rbpl_pkg::ST_MISSING);
      end
    endcase
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    rbpl_pkg::out_t e;
    if (!rst_n) begin
      head_q = '0;
      count_q = 0;
      keep_tags = 1'b0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) keep_tags = pwdata[0];
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.result_value !== e.result_value) begin
            $error("result_value exp %h got %h", e.result_value, out_data.result_value);
            fail_count++;
          end
          if (out_data.result_type !== e.result_type) begin
            $error("result_type exp %h got %h", e.result_type, out_data.result_type);
            fail_count++;
          end
          if (out_data.result_index !== e.result_index) begin
            $error("result_index exp %0d got %0d", e.result_index, out_data.result_index);
            fail_count++;
          end
          if (out_data.entries_now !== e.entries_now) begin
            $error("entries_now exp %0d got %0d", e.entries_now, out_data.entries_now);
            fail_count++;
          end
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) apply_op(in_data);
    end
    pending_results = expected_q.size();
  end
endmodule

// ----- verif/tb_ring_buffer_positional_list_top.sv -----
// testbench top: stimulus, idling, configuration and the verdict
module tb_ring_buffer_positional_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  rbpl_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rbpl_pkg::out_t out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;
  int             fail_count;
  int             pending_results;
  int             cycle_count = 0;
  bit             calm = 1'b0;
  bit             stall_req = 1'b0;
  bit             stall_seen = 1'b0;
  int             hold_off = 0;
  logic [31:0]    value_pool [8];

  always #2 clk = ~clk;

  ring_buffer_positional_list_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rbpl_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending_results
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("ring_buffer_positional_list_top: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off counted here
  always @(posedge clk) begin
    if (stall_req && !stall_seen) begin
      stall_seen <= 1'b1;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  task automatic write_tags(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send(logic [2:0] k, int pos, logic [31:0] v, logic [15:0] t);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= '{kind: k, position: 7'(pos), value: v, entry_type: t};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_op();
    int          r;
    logic [2:0]  k;
    logic [31:0] v;
    r = $urandom_range(99);
    k = r < 30 ? rbpl_pkg::K_INSERT : r < 40 ? rbpl_pkg::K_PREPEND : 3'($urandom_range(7));
    v = $urandom_range(3) == 0 ? $urandom : value_pool[$urandom_range(7)];
    send(k, $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(66), v,
         16'($urandom));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
    value_pool[0] = 32'd0;
    value_pool[1] = 32'hffff_ffff;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty-list errors, every operation, edge values
    send(rbpl_pkg::K_GET, 0, 0, 0);
    send(rbpl_pkg::K_REMOVE_ALL, 0, 0, 0);
    send(rbpl_pkg::K_INSERT, 1, 1, 16'h7fff);
    send(rbpl_pkg::K_INSERT, 0, 32'hffff_ffff, 16'h8000);
    send(rbpl_pkg::K_PREPEND, 0, 0, 16'hffff);
    send(rbpl_pkg::K_INSERT, 3, 32'h5a5a_a5a5, 16'h0001);
    send(rbpl_pkg::K_SET, 1, 32'h1234_5678, 16'h7fff);
    send(rbpl_pkg::K_SET, 4, 0, 0);
    send(rbpl_pkg::K_GET, 127, 0, 0);
    send(rbpl_pkg::K_FIND, 0, 32'hffff_ffff, 0);
    send(rbpl_pkg::K_FIND, 0, 32'h1234_5678, 0);
    send(rbpl_pkg::K_REMOVE_ONE, 0, 32'h5a5a_a5a5, 0);
    send(rbpl_pkg::K_REMOVE, 0, 0, 0);
    send(rbpl_pkg::K_REMOVE, 1, 0, 0);
    send(rbpl_pkg::K_PREPEND, 0, 32'h0, 0);
    send(rbpl_pkg::K_REMOVE_ALL, 0, 32'h0, 0);
    drain();
    write_tags(32'd1);
    for (int ph = 0; ph < 4; ph++) begin
      // fill to capacity, then exercise full status
      calm = (ph == 1);
      for (int i = 0; i < 70; i++)
        send(i % 2 ? rbpl_pkg::K_PREPEND : rbpl_pkg::K_INSERT, $urandom_range(2),
             value_pool[$urandom_range(7)], 16'($urandom));
      if (ph == 2) stall_req = 1'b1;
      for (int i = 0; i < 230; i++) random_op();
      send(rbpl_pkg::K_REMOVE_ALL, 0, value_pool[$urandom_range(7)], 0);
      drain();
      write_tags(ph % 2 ? 32'hffff_fffe : 32'hffff_ffff);
    end
    drain();
    if (fail_count == 0) begin
      $display("ring_buffer_positional_list_top: match");
    end else begin
      $display("ring_buffer_positional_list_top: mismatch");
    end
    $finish;
  end
endmodule
